// ===== rtl/key_index_insertion_sorter_unit_assert.svh =====
// Assertion macros for the key/index insertion sorter.
`ifndef KEY_INDEX_INSERTION_SORTER_UNIT_ASSERT_SVH
`define KEY_INDEX_INSERTION_SORTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define KIIS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kiis assertion failed");

`define KIIS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("kiis forbidden condition seen");

`else

`define KIIS_ASSERT(lbl, prop)

`define KIIS_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/kiis_pkg.sv =====
// Shared types and constants for the key/index insertion sorter.
`timescale 1ns / 1ps

package kiis_pkg;

    localparam int CAPACITY = 64;
    localparam int TAG_BITS = 16;
    localparam int KEY_BITS = 64;
    localparam int TAG_PORT_BITS = 16;
    localparam int STORED_TAG_BITS = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;

    typedef struct packed {
        logic [KEY_BITS-1:0]        key;
        logic [STORED_TAG_BITS-1:0] tag;
    } t_elem;

    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

// ===== rtl/key_index_insertion_sorter_unit.sv =====
// Insertion sorter: a chain of cells that keeps (key, tag) words in ascending key order.
// Load: one word accepted per cycle, placed in the chain in that same cycle (dropped if full).
// Drain: after the word flagged final_item, results follow from the next cycle, one per
// cycle while the output is ready; input reopens once the last stored word is taken.
// Input is not accepted while a set drains. Reset (synchronous, active low) empties the
// chain and clears the overflow flag.
`timescale 1ns / 1ps

`include "key_index_insertion_sorter_unit_assert.svh"

module key_index_insertion_sorter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_sort_key,
    input  logic [15:0] i_tag,
    input  logic        i_final_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_sorted_key,
    output logic [15:0] o_sorted_tag,
    output logic        o_end_of_run,
    output logic        o_overflow
);

    localparam int CAP = kiis_pkg::CAPACITY;

    kiis_pkg::t_state     r_state;
    kiis_pkg::t_state     n_state;
    logic                 r_dropped;
    logic                 n_dropped;
    kiis_pkg::t_cell_ctrl w_ctrl;
    kiis_pkg::t_elem      w_new;
    kiis_pkg::t_elem      w_elem [CAP];
    logic [CAP-1:0]       w_valid;
    logic [CAP-1:0]       w_take;
    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_full;
    logic                 w_drain_done;

    assign w_new.key = i_sort_key;
    assign w_new.tag = i_tag[kiis_pkg::STORED_TAG_BITS-1:0];

    assign w_full       = w_valid[CAP-1];
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_out_acc    = o_out_valid && i_out_ready;
    assign w_drain_done = w_out_acc && !w_valid[1];

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            kiis_pkg::t_elem w_prev;
            logic            w_prev_valid;
            logic            w_prev_take;
            kiis_pkg::t_elem w_next;
            logic            w_next_valid;

            if (gi == 0) begin : g_head
                assign w_prev       = w_new;
                assign w_prev_valid = 1'b0;
                assign w_prev_take  = 1'b0;
            end else begin : g_body
                assign w_prev       = w_elem[gi-1];
                assign w_prev_valid = w_valid[gi-1];
                assign w_prev_take  = w_take[gi-1];
            end

            if (gi == CAP - 1) begin : g_tail
                assign w_next       = w_new;
                assign w_next_valid = 1'b0;
            end else begin : g_inner
                assign w_next       = w_elem[gi+1];
                assign w_next_valid = w_valid[gi+1];
            end

            kiis_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_prev       (w_prev),
                .i_prev_valid (w_prev_valid),
                .i_prev_take  (w_prev_take),
                .i_next       (w_next),
                .i_next_valid (w_next_valid),
                .o_elem       (w_elem[gi]),
                .o_valid      (w_valid[gi]),
                .o_take       (w_take[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            kiis_pkg::ST_LOAD: begin
                if (w_in_acc && i_final_item) begin
                    n_state = kiis_pkg::ST_DRAIN;
                end
            end
            kiis_pkg::ST_DRAIN: begin
                if (w_drain_done) begin
                    n_state = kiis_pkg::ST_LOAD;
                end
            end
            default: n_state = kiis_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        w_ctrl.insert = 1'b0;
        w_ctrl.drain  = 1'b0;
        n_dropped     = r_dropped;
        case (r_state)
            kiis_pkg::ST_LOAD: begin
                o_in_ready    = 1'b1;
                w_ctrl.insert = w_in_acc && !w_full;
                if (w_in_acc && w_full) begin
                    n_dropped = 1'b1;
                end
            end
            kiis_pkg::ST_DRAIN: begin
                o_out_valid  = w_valid[0];
                w_ctrl.drain = w_out_acc;
                if (w_drain_done) begin
                    n_dropped = 1'b0;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kiis_pkg::ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    assign o_sorted_key = w_elem[0].key;
    assign o_sorted_tag = 16'(w_elem[0].tag);
    assign o_end_of_run = !w_valid[1];
    assign o_overflow   = r_dropped;

    logic [CAP-1:0] w_valid_inc;
    assign w_valid_inc = w_valid + 1'b1;

    `KIIS_NEVER(a_no_load_while_drain, o_in_ready && o_out_valid)
    `KIIS_ASSERT(a_valid_prefix, (w_valid_inc & w_valid) == '0)
    `KIIS_ASSERT(a_drain_nonempty, (r_state == kiis_pkg::ST_DRAIN) |-> w_valid[0])
    `KIIS_ASSERT(a_empty_after_run, (w_out_acc && o_end_of_run) |=> (w_valid == '0))

endmodule

// ===== rtl/kiis_cell.sv =====
// One cell of the insertion chain: holds one element and shifts with its neighbors.
`timescale 1ns / 1ps

module kiis_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kiis_pkg::t_cell_ctrl i_ctrl,
    input  kiis_pkg::t_elem      i_new,
    input  kiis_pkg::t_elem      i_prev,
    input  logic                 i_prev_valid,
    input  logic                 i_prev_take,
    input  kiis_pkg::t_elem      i_next,
    input  logic                 i_next_valid,
    output kiis_pkg::t_elem      o_elem,
    output logic                 o_valid,
    output logic                 o_take
);

    kiis_pkg::t_elem r_elem;
    kiis_pkg::t_elem n_elem;
    logic            r_valid;
    logic            n_valid;

    // strict less-than keeps equal keys in arrival order
    assign o_take  = !r_valid || (i_new.key < r_elem.key);
    assign o_elem  = r_elem;
    assign o_valid = r_valid;

    always_comb begin
        n_elem  = r_elem;
        n_valid = r_valid;
        if (i_ctrl.drain) begin
            n_elem  = i_next;
            n_valid = i_next_valid;
        end else if (i_ctrl.insert) begin
            if (i_prev_take) begin
                n_elem  = i_prev;
                n_valid = i_prev_valid;
            end else if (o_take) begin
                n_elem  = i_new;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
    end

endmodule

// ===== dv/tb_key_index_insertion_sorter_unit.sv =====
// Testbench for the key/index insertion sorter: sets of words in, sorted drain checked.
`timescale 1ns / 1ps

module tb_key_index_insertion_sorter_unit;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] tag;
        logic        last;
        logic        ovf;
    } t_sorted_word;

    typedef enum logic [1:0] {
        KEY_ANY,
        KEY_NARROW,
        KEY_DOUBLE,
        KEY_CORNER
    } t_key_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_sort_key = '0;
    logic [15:0] i_tag = '0;
    logic        i_final_item = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_sorted_key;
    logic [15:0] o_sorted_tag;
    logic        o_end_of_run;
    logic        o_overflow;

    kiis_pkg::t_elem loaded_set[$];
    bit              set_dropped = 1'b0;
    t_sorted_word    sorted_due[$];
    int              err_count = 0;
    int              words_sent = 0;
    bit              no_idle = 1'b0;
    int              rx_hold_cycles = 0;

    key_index_insertion_sorter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sort_key   (i_sort_key),
        .i_tag        (i_tag),
        .i_final_item (i_final_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sorted_key (o_sorted_key),
        .o_sorted_tag (o_sorted_tag),
        .o_end_of_run (o_end_of_run),
        .o_overflow   (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    // insert behind equal keys; closing word flushes the set in ascending order
    function automatic void sort_accepted_word(logic [63:0] k, logic [15:0] t, logic f);
        kiis_pkg::t_elem e;
        t_sorted_word    w;
        int              pos;
        e.key = k;
        e.tag = t[kiis_pkg::STORED_TAG_BITS-1:0];
        if (loaded_set.size() < kiis_pkg::CAPACITY) begin
            pos = loaded_set.size();
            while (pos > 0 && k < loaded_set[pos-1].key)
                pos--;
            loaded_set.insert(pos, e);
        end else begin
            set_dropped = 1'b1;
        end
        if (f) begin
            foreach (loaded_set[i]) begin
                w.key  = loaded_set[i].key;
                w.tag  = 16'(loaded_set[i].tag);
                w.last = (i == loaded_set.size() - 1);
                w.ovf  = set_dropped;
                sorted_due.push_back(w);
            end
            loaded_set.delete();
            set_dropped = 1'b0;
        end
    endfunction

    function automatic logic [63:0] pick_key(t_key_mode mode);
        logic [63:0] k;
        case (mode)
            KEY_NARROW: k = 64'($urandom_range(0, 3));
            KEY_DOUBLE: k = {1'b0, 11'($urandom_range(1000, 1100)), 52'({$urandom, $urandom})};
            KEY_CORNER: begin
                case ($urandom_range(0, 4))
                    0: k = '0;
                    1: k = '1;
                    2: k = 64'h1;
                    3: k = 64'h8000_0000_0000_0000;
                    default: k = 64'h7FF0_0000_0000_0000;
                endcase
            end
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    // returns right after the accepting edge; the next call or end_input moves valid
    task automatic send_word(logic [63:0] k, logic [15:0] t, logic f);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sort_key   <= k;
        i_tag        <= t;
        i_final_item <= f;
        do @(posedge i_clk); while (!o_in_ready);
        sort_accepted_word(k, t, f);
        words_sent++;
    endtask

    task automatic end_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_set(int n, t_key_mode mode);
        for (int i = 0; i < n; i++)
            send_word(pick_key(mode), 16'($urandom), i == n - 1);
    endtask

    task automatic test_single_element();
        send_word('1, 16'hFFFF, 1'b1);
        send_word('0, 16'h0000, 1'b1);
    endtask

    task automatic test_order_and_ties();
        send_word('1, 16'h0001, 1'b0);
        send_word(64'h7FF0_0000_0000_0000, 16'h0002, 1'b0);
        send_word(64'h3FF0_0000_0000_0000, 16'h8000, 1'b0);
        send_word(64'h1, 16'h5555, 1'b0);
        send_word('0, 16'hAAAA, 1'b1);
        // equal keys must leave in arrival order
        send_word(64'h4000_0000_0000_0000, 16'h0011, 1'b0);
        send_word(64'h4000_0000_0000_0000, 16'h0012, 1'b0);
        send_word(64'h3000_0000_0000_0000, 16'h0013, 1'b0);
        send_word(64'h4000_0000_0000_0000, 16'h0014, 1'b0);
        send_word(64'h4000_0000_0000_0000, 16'h0015, 1'b1);
        send_word(64'h10, 16'h7FFF, 1'b0);
        send_word(64'h20, 16'hFFFE, 1'b0);
        send_word(64'h30, 16'h0100, 1'b0);
        send_word(64'h40, 16'h00FF, 1'b1);
    endtask

    task automatic test_capacity_limit();
        // full store: extra words dropped, closing word dropped too
        send_set(kiis_pkg::CAPACITY + 2, KEY_NARROW);
    endtask

    task automatic test_receiver_hold();
        rx_hold_cycles = 300;
        no_idle = 1'b1;
        send_set(8, KEY_DOUBLE);
        send_set(4, KEY_ANY);
        no_idle = 1'b0;
    endtask

    task automatic test_random_sets();
        int stop_at;
        int n;
        stop_at = words_sent + 64;
        while (words_sent < stop_at) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, kiis_pkg::CAPACITY + 4)
                                            : $urandom_range(1, 8);
            if (n > stop_at - words_sent)
                n = stop_at - words_sent;
            no_idle = ($urandom_range(0, 3) == 0);
            send_set(n, t_key_mode'($urandom_range(0, 3)));
        end
        no_idle = 1'b0;
    endtask

    initial begin : rx_side
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_sorted_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sorted_due.size() == 0) begin
                $error("unexpected word: key %h tag %h", o_sorted_key, o_sorted_tag);
                err_count++;
            end else begin
                want = sorted_due.pop_front();
                if (o_sorted_key !== want.key) begin
                    $error("sorted_key mismatch: expected %h, got %h", want.key, o_sorted_key);
                    err_count++;
                end
                if (o_sorted_tag !== want.tag) begin
                    $error("sorted_tag mismatch: expected %h, got %h", want.tag, o_sorted_tag);
                    err_count++;
                end
                if (o_end_of_run !== want.last) begin
                    $error("end_of_run mismatch: expected %b, got %b", want.last, o_end_of_run);
                    err_count++;
                end
                if (o_overflow !== want.ovf) begin
                    $error("overflow mismatch: expected %b, got %b", want.ovf, o_overflow);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main
        int waited;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_single_element();
        test_order_and_ties();
        test_capacity_limit();
        test_receiver_hold();
        test_random_sets();
        end_input();
        waited = 0;
        while (sorted_due.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (sorted_due.size() != 0) begin
            $error("%0d sorted words never arrived", sorted_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
